>>> hw/rtl/frame_transmit_ring_queue_assert.svh
// Assertion macros used by the ring queue RTL.
`ifndef FRAME_TRANSMIT_RING_QUEUE_ASSERT_SVH
`define FRAME_TRANSMIT_RING_QUEUE_ASSERT_SVH

`ifndef SYNTHESIS
`define FTRQ_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);
`define FTRQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FTRQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define FTRQ_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

>>> hw/rtl/ftrq_pkg.sv
package ftrq_pkg;

	localparam int unsigned ID_W      = 11;
	localparam int unsigned LEN_W     = 4;
	localparam int unsigned DATA_W    = 64;
	localparam int unsigned PENDING_W = 4;
	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(8);

	typedef enum logic [1:0] {
		FUNC_PUSH    = 2'd0,
		FUNC_DONE    = 2'd1,
		FUNC_RECOVER = 2'd2,
		FUNC_KICK    = 2'd3
	} func_t;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [LEN_W-1:0]  len;
		logic [DATA_W-1:0] data;
	} frame_t;

	function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len);
		return (len > MAX_LEN) ? MAX_LEN : len;
	endfunction

endpackage

>>> hw/rtl/frame_transmit_ring_queue.sv
// Transmit ring queue for standard bus frames.
// Input channel (item_valid / item_stall) carries one operation per transfer:
// push a frame, transmit complete, bus recovered or kick, plus the
// transmitter's tx_ready sample. Output channel (res_valid / res_stall)
// returns exactly one result per operation, in order: status, the frame
// started (zero fields when none), frames pending and the busy flag.
// Each operation passes the input register, then the ring update and the
// result register, before its result is valid. One operation is accepted
// every cycle while item_stall is low; the ring pointers and the busy flag
// update in the same cycle as the operation is evaluated, so back-to-back
// operations see each other's effect. Frames live in a RAM with registered
// read; the read address is chosen from the incoming operation in the cycle
// before it is evaluated, and a frame written in the previous cycle is
// forwarded around the RAM.
// Reset clears pointers (queue empty), the busy flag and both valid stages;
// frame storage is not cleared. While res_stall holds a result, the input
// register takes at most one more operation and item_stall is high as long
// as that register is occupied.
module frame_transmit_ring_queue
	import ftrq_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  logic [1:0]        func,
	input  logic [ID_W-1:0]   frame_id,
	input  logic [LEN_W-1:0]  frame_len,
	input  logic [DATA_W-1:0] frame_data,
	input  logic              tx_ready,
	output logic              res_valid,
	input  logic              res_stall,
	output logic              status,
	output logic              send_start,
	output logic [ID_W-1:0]   send_id,
	output logic [LEN_W-1:0]  send_len,
	output logic [DATA_W-1:0] send_data,
	output logic [PENDING_W-1:0] pending,
	output logic              busy_res
);

`include "frame_transmit_ring_queue_assert.svh"

	localparam int unsigned AW   = $clog2(QUEUE_DEPTH);
	localparam int unsigned PEXT = (AW > PENDING_W) ? AW : PENDING_W;
	localparam int unsigned CW   = PEXT + 1;

	function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p);
		return (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	// input stage
	logic        valid_s1;
	func_t       func_s1;
	frame_t      frame_s1;
	logic        ready_s1;

	// ring state
	logic [AW-1:0] wp_q, rp_q;
	logic          busy_q;

	// forwarding around the RAM
	logic   fwd_hit_q;
	frame_t fwd_frame_q;
	frame_t ram_rdata;

	// result register
	logic              res_valid_q;
	logic              status_q, start_q, busy_res_q;
	frame_t            send_q;
	logic [PENDING_W-1:0] pending_q;

	logic out_free, adv_s1, item_xfer;
	assign out_free   = !res_valid_q || !res_stall;
	assign adv_s1     = valid_s1 && out_free;
	assign item_stall = valid_s1 && !out_free;
	assign item_xfer  = item_valid && !item_stall;

	// step logic
	logic          empty_c, full_c, try_c, we_c, start_c, st_c;
	logic [AW-1:0] wp_n, rp_n;
	logic          busy_n;
	frame_t        head_c, send_c;
	logic [CW-1:0] pend_c;

	always_comb begin
		empty_c = (wp_q == rp_q);
		full_c  = (ring_next(wp_q) == rp_q);
		wp_n    = wp_q;
		rp_n    = rp_q;
		busy_n  = busy_q;
		try_c   = 1'b0;
		we_c    = 1'b0;
		st_c    = 1'b0;
		start_c = 1'b0;
		unique case (func_s1)
			FUNC_PUSH: begin
				if (full_c) begin
					st_c = 1'b1;
				end else begin
					we_c  = 1'b1;
					wp_n  = ring_next(wp_q);
					try_c = 1'b1;
				end
			end
			FUNC_DONE: begin
				busy_n = 1'b0;
				if (empty_c) begin
					st_c = 1'b1;
				end else begin
					rp_n  = ring_next(rp_q);
					try_c = 1'b1;
				end
			end
			FUNC_RECOVER: begin
				busy_n = 1'b0;
				try_c  = 1'b1;
			end
			FUNC_KICK: begin
				try_c = 1'b1;
			end
			default: begin
				try_c = 1'b0;
			end
		endcase
		if (try_c && (wp_n != rp_n) && !busy_n) begin
			if (ready_s1) begin
				busy_n  = 1'b1;
				start_c = 1'b1;
			end else begin
				st_c = 1'b1;
			end
		end
		// push into an empty ring starts the frame just pushed
		if (func_s1 == FUNC_PUSH && empty_c) begin
			head_c = frame_s1;
		end else if (fwd_hit_q) begin
			head_c = fwd_frame_q;
		end else begin
			head_c = ram_rdata;
		end
		send_c = start_c ? head_c : '0;
		if (wp_n >= rp_n) begin
			pend_c = CW'(wp_n) - CW'(rp_n);
		end else begin
			pend_c = CW'(QUEUE_DEPTH) - CW'(rp_n) + CW'(wp_n);
		end
	end

	// read address is set up for whatever op sits in the input stage next cycle
	func_t         rd_func;
	logic [AW-1:0] rd_base, rd_addr;
	assign rd_func = item_xfer ? func_t'(func) : func_s1;
	assign rd_base = adv_s1 ? rp_n : rp_q;
	assign rd_addr = (rd_func == FUNC_DONE) ? ring_next(rd_base) : rd_base;

	ftrq_ram #(
		.WIDTH ($bits(frame_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_slots (
		.clk   (clk),
		.we    (adv_s1 && we_c),
		.waddr (wp_q),
		.wdata (frame_s1),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_xfer) begin
			func_s1       <= func_t'(func);
			frame_s1.id   <= frame_id;
			frame_s1.len  <= clamp_len(frame_len);
			frame_s1.data <= frame_data;
			ready_s1      <= tx_ready;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q      <= '0;
			rp_q      <= '0;
			busy_q    <= 1'b0;
			fwd_hit_q <= 1'b0;
		end else begin
			fwd_hit_q <= adv_s1 && we_c && (wp_q == rd_addr);
			if (adv_s1) begin
				wp_q   <= wp_n;
				rp_q   <= rp_n;
				busy_q <= busy_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		fwd_frame_q <= frame_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_free) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			status_q   <= st_c;
			start_q    <= start_c;
			send_q     <= send_c;
			pending_q  <= pend_c[PENDING_W-1:0];
			busy_res_q <= busy_n;
		end
	end

	assign res_valid  = res_valid_q;
	assign status     = status_q;
	assign send_start = start_q;
	assign send_id    = send_q.id;
	assign send_len   = send_q.len;
	assign send_data  = send_q.data;
	assign pending    = pending_q;
	assign busy_res   = busy_res_q;

	`FTRQ_ASSERT(a_ptr_range, clk, arst_n, ({1'b0, wp_q} < (AW+1)'(QUEUE_DEPTH)) && ({1'b0, rp_q} < (AW+1)'(QUEUE_DEPTH)), "ring pointer out of range")
	`FTRQ_ASSERT(a_busy_nonempty, clk, arst_n, busy_q |-> (wp_q != rp_q), "transmitter busy with empty ring")
	`FTRQ_ASSERT(a_start_busy, clk, arst_n, (res_valid_q && start_q) |-> (busy_res_q && !status_q), "start reported without busy or with error")
	`FTRQ_ASSERT(a_push_adv, clk, arst_n, (adv_s1 && we_c) |=> (wp_q != $past(wp_q)), "accepted push did not advance write pointer")
	`FTRQ_ASSERT_ALWAYS(a_reset_idle, clk, !arst_n |-> (!res_valid && !busy_q), "result or busy flag set during reset")

endmodule

>>> hw/rtl/ftrq_ram.sv
module ftrq_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
